// ----- src/stc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil texture classifier package
// Widths, class codes and the constant triangle table of the texture chart.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int ShareW  = 24;            // Q8.16 input share
  localparam int ClassW  = 4;
  localparam int PtW     = 26;            // scaled share, up to 1000 percent
  localparam int DiffW   = PtW + 2;       // point minus vertex, signed
  localparam int EdgeW   = 9;             // vertex difference, signed
  localparam int CrossW  = 38;            // cross product component, signed
  localparam int SumW    = ShareW + 2;
  localparam int NumTris = 29;

  localparam logic [SumW-1:0] FracLimit = SumW'(10 * 65536);
  localparam logic [PtW-1:0]  ScaleBy   = PtW'(100);

  localparam logic signed [CrossW-1:0] QOne    = CrossW'(65536);
  localparam logic signed [CrossW-1:0] NegQOne = -QOne;

  typedef enum logic [ClassW-1:0] {
    TC_CLAY            = 4'd0,
    TC_SANDY_CLAY      = 4'd1,
    TC_SILTY_CLAY      = 4'd2,
    TC_SANDY_CLAY_LOAM = 4'd3,
    TC_CLAY_LOAM       = 4'd4,
    TC_SILTY_CLAY_LOAM = 4'd5,
    TC_SAND            = 4'd6,
    TC_LOAMY_SAND      = 4'd7,
    TC_SANDY_LOAM      = 4'd8,
    TC_LOAM            = 4'd9,
    TC_SILT_LOAM       = 4'd10,
    TC_SILT            = 4'd11,
    TC_NONE            = 4'd12
  } texture_e;

  typedef logic [7:0]        pct_t;
  typedef pct_t [0:2]        vert_t;   // sand, clay, silt
  typedef logic [PtW-1:0]    pt_t;
  typedef pt_t [0:2]         point_t;

  typedef struct packed {
    texture_e     cls;
    vert_t [0:2]  v;
  } tri_t;

  localparam tri_t TriTable [NumTris] = '{
    '{TC_CLAY, '{'{8'd0, 8'd100, 8'd0}, '{8'd0, 8'd60, 8'd40}, '{8'd20, 8'd40, 8'd40}}},
    '{TC_CLAY, '{'{8'd0, 8'd100, 8'd0}, '{8'd20, 8'd40, 8'd40}, '{8'd50, 8'd40, 8'd10}}},
    '{TC_CLAY, '{'{8'd0, 8'd100, 8'd0}, '{8'd50, 8'd40, 8'd10}, '{8'd50, 8'd50, 8'd0}}},
    '{TC_SANDY_CLAY,
      '{'{8'd50, 8'd50, 8'd0}, '{8'd50, 8'd35, 8'd15}, '{8'd65, 8'd35, 8'd0}}},
    '{TC_SILTY_CLAY,
      '{'{8'd0, 8'd60, 8'd40}, '{8'd0, 8'd40, 8'd60}, '{8'd20, 8'd40, 8'd40}}},
    '{TC_SANDY_CLAY_LOAM,
      '{'{8'd65, 8'd35, 8'd0}, '{8'd50, 8'd35, 8'd15}, '{8'd50, 8'd30, 8'd20}}},
    '{TC_SANDY_CLAY_LOAM,
      '{'{8'd65, 8'd35, 8'd0}, '{8'd50, 8'd30, 8'd20}, '{8'd55, 8'd25, 8'd20}}},
    '{TC_SANDY_CLAY_LOAM,
      '{'{8'd65, 8'd35, 8'd0}, '{8'd55, 8'd25, 8'd20}, '{8'd75, 8'd25, 8'd0}}},
    '{TC_CLAY_LOAM,
      '{'{8'd20, 8'd40, 8'd40}, '{8'd20, 8'd30, 8'd50}, '{8'd50, 8'd30, 8'd20}}},
    '{TC_CLAY_LOAM,
      '{'{8'd20, 8'd40, 8'd40}, '{8'd50, 8'd30, 8'd20}, '{8'd10, 8'd50, 8'd40}}},
    '{TC_SILTY_CLAY_LOAM,
      '{'{8'd0, 8'd40, 8'd60}, '{8'd0, 8'd30, 8'd70}, '{8'd20, 8'd30, 8'd50}}},
    '{TC_SILTY_CLAY_LOAM,
      '{'{8'd0, 8'd40, 8'd60}, '{8'd20, 8'd30, 8'd50}, '{8'd20, 8'd40, 8'd40}}},
    '{TC_SAND, '{'{8'd85, 8'd15, 8'd0}, '{8'd85, 8'd0, 8'd15}, '{8'd100, 8'd0, 8'd0}}},
    '{TC_LOAMY_SAND,
      '{'{8'd80, 8'd20, 8'd0}, '{8'd70, 8'd0, 8'd30}, '{8'd85, 8'd0, 8'd15}}},
    '{TC_LOAMY_SAND,
      '{'{8'd80, 8'd20, 8'd0}, '{8'd85, 8'd0, 8'd15}, '{8'd85, 8'd15, 8'd0}}},
    '{TC_SANDY_LOAM,
      '{'{8'd55, 8'd10, 8'd35}, '{8'd40, 8'd10, 8'd50}, '{8'd50, 8'd0, 8'd50}}},
    '{TC_SANDY_LOAM,
      '{'{8'd55, 8'd10, 8'd35}, '{8'd50, 8'd0, 8'd50}, '{8'd70, 8'd0, 8'd30}}},
    '{TC_SANDY_LOAM,
      '{'{8'd55, 8'd10, 8'd35}, '{8'd70, 8'd0, 8'd30}, '{8'd80, 8'd20, 8'd0}}},
    '{TC_SANDY_LOAM,
      '{'{8'd55, 8'd10, 8'd35}, '{8'd80, 8'd20, 8'd0}, '{8'd75, 8'd25, 8'd0}}},
    '{TC_SANDY_LOAM,
      '{'{8'd55, 8'd10, 8'd35}, '{8'd75, 8'd25, 8'd0}, '{8'd55, 8'd25, 8'd20}}},
    '{TC_LOAM, '{'{8'd50, 8'd30, 8'd20}, '{8'd20, 8'd30, 8'd50}, '{8'd40, 8'd10, 8'd50}}},
    '{TC_LOAM, '{'{8'd50, 8'd30, 8'd20}, '{8'd40, 8'd10, 8'd50}, '{8'd55, 8'd10, 8'd35}}},
    '{TC_LOAM, '{'{8'd50, 8'd30, 8'd20}, '{8'd55, 8'd10, 8'd35}, '{8'd55, 8'd25, 8'd15}}},
    '{TC_SILT_LOAM,
      '{'{8'd15, 8'd10, 8'd75}, '{8'd25, 8'd0, 8'd75}, '{8'd50, 8'd0, 8'd50}}},
    '{TC_SILT_LOAM,
      '{'{8'd15, 8'd10, 8'd75}, '{8'd50, 8'd0, 8'd50}, '{8'd20, 8'd30, 8'd50}}},
    '{TC_SILT_LOAM,
      '{'{8'd15, 8'd10, 8'd75}, '{8'd20, 8'd30, 8'd50}, '{8'd0, 8'd30, 8'd70}}},
    '{TC_SILT_LOAM,
      '{'{8'd15, 8'd10, 8'd75}, '{8'd0, 8'd30, 8'd70}, '{8'd0, 8'd10, 8'd90}}},
    '{TC_SILT, '{'{8'd15, 8'd10, 8'd75}, '{8'd0, 8'd10, 8'd90}, '{8'd0, 8'd0, 8'd100}}},
    '{TC_SILT, '{'{8'd15, 8'd10, 8'd75}, '{8'd0, 8'd0, 8'd100}, '{8'd25, 8'd0, 8'd75}}}
  };

endpackage

// ----- src/stc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil texture classifier channels
// Sample channel (three shares) and result channel (class code).
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ShareW-1:0] sand_share;
  logic [ShareW-1:0] clay_share;
  logic [ShareW-1:0] silt_share;

  modport source (output valid, sand_share, clay_share, silt_share, input ready);
  modport sink   (input valid, sand_share, clay_share, silt_share, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ClassW-1:0] texture_class;

  modport source (output valid, texture_class, input ready);
  modport sink   (input valid, texture_class, output ready);
endinterface

// ----- src/stc_tri_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle containment test
// Edge cross products of one chart triangle against the point, sign voting.
// ----------------------------------------------------------------------------
module stc_tri_test import stc_pkg::*; (
  input  tri_t   tri_i,
  input  point_t pt_i,
  output logic   hit_o
);

  logic signed [DiffW-1:0]  diff  [3][3];
  logic signed [EdgeW-1:0]  edg   [3][3];
  logic signed [CrossW-1:0] diffx [3][3];
  logic signed [CrossW-1:0] edgx  [3][3];
  logic signed [CrossW-1:0] crs   [3][3];
  logic [2:0] ge_all;
  logic [2:0] le_all;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        diff[k][i]  = $signed({2'b00, pt_i[i]}) - $signed({4'b0000, tri_i.v[k][i], 16'h0000});
        edg[k][i]   = $signed({1'b0, tri_i.v[(k + 1) % 3][i]}) - $signed({1'b0, tri_i.v[k][i]});
        diffx[k][i] = CrossW'(diff[k][i]);
        edgx[k][i]  = CrossW'(edg[k][i]);
      end
      crs[k][0] = diffx[k][1] * edgx[k][2] - diffx[k][2] * edgx[k][1];
      crs[k][1] = diffx[k][2] * edgx[k][0] - diffx[k][0] * edgx[k][2];
      crs[k][2] = diffx[k][0] * edgx[k][1] - diffx[k][1] * edgx[k][0];
    end
    for (int i = 0; i < 3; i++) begin
      ge_all[i] = (crs[0][i] > NegQOne) && (crs[1][i] > NegQOne) && (crs[2][i] > NegQOne);
      le_all[i] = (crs[0][i] < QOne) && (crs[1][i] < QOne) && (crs[2][i] < QOne);
    end
    hit_o = (&ge_all) | (&(~ge_all & le_all));
  end

endmodule

// ----- src/soil_texture_triangle_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil texture triangle classifier
// Takes one sample (sand, clay, silt as unsigned Q8.16) per clock and returns
// its texture class, 12 when no chart triangle holds the point. Two register
// stages: the sample, if given as fractions, is scaled to percent on the way
// into the point register, then all 29 triangle tests run side by side with a
// first-hit select into the result register. Throughput is one beat per cycle
// when not stalled; the triangle tests and priority select set the critical
// path. A held result stalls the point stage, and only then the sample channel.
// ----------------------------------------------------------------------------
module soil_texture_triangle_classifier import stc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_in_if.sink    sample_i,
  stc_out_if.source result_o
);

  logic            pt_vld_q;
  logic            res_vld_q;
  point_t          pt_d;
  point_t          pt_q;
  texture_e        cls_d;
  texture_e        cls_q;
  logic            adv_res;
  logic            in_ready;
  logic [SumW-1:0] share_sum;
  logic            is_frac;
  logic [NumTris-1:0] hit;

  assign adv_res  = !res_vld_q || result_o.ready;
  assign in_ready = !pt_vld_q || adv_res;

  assign sample_i.ready         = in_ready;
  assign result_o.valid         = res_vld_q;
  assign result_o.texture_class = cls_q;

  // scale fractions to percent
  always_comb begin
    share_sum = SumW'(sample_i.sand_share) + SumW'(sample_i.clay_share)
              + SumW'(sample_i.silt_share);
    is_frac   = share_sum <= FracLimit;
    pt_d[0]   = PtW'(sample_i.sand_share);
    pt_d[1]   = PtW'(sample_i.clay_share);
    pt_d[2]   = PtW'(sample_i.silt_share);
    if (is_frac) begin
      for (int i = 0; i < 3; i++) begin
        pt_d[i] = pt_d[i] * ScaleBy;
      end
    end
  end

  for (genvar t = 0; t < NumTris; t++) begin : g_tri
    stc_tri_test u_tri (
      .tri_i (TriTable[t]),
      .pt_i  (pt_q),
      .hit_o (hit[t])
    );
  end

  // first hit in table order wins
  always_comb begin
    cls_d = TC_NONE;
    for (int t = NumTris - 1; t >= 0; t--) begin
      if (hit[t]) begin
        cls_d = TriTable[t].cls;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        pt_vld_q <= sample_i.valid;
      end
      if (adv_res) begin
        res_vld_q <= pt_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && sample_i.valid) begin
      pt_q <= pt_d;
    end
    if (adv_res && pt_vld_q) begin
      cls_q <= cls_d;
    end
  end

endmodule

// ----- src/stc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil texture classifier checker
// Port-level properties of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker import stc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ClassW-1:0] texture_class_i
);

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (texture_class_i <= ClassW'(TC_NONE)))
    else $error("class code out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(texture_class_i))
    else $error("stalled result beat changed");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("sample channel stalled with empty result stage");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("accepted beat did not reach the result stage");

endmodule

bind soil_texture_triangle_classifier stc_checker u_stc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (sample_i.valid),
  .in_ready_i      (sample_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .texture_class_i (result_o.texture_class)
);
